// File: rtl/prc_pkg.sv
// Package: shared types and constants of the phase resistance calibrator.
package prc_pkg;
    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_RUN   = 3'd1;
    localparam logic [2:0] ST_OK    = 3'd2;
    localparam logic [2:0] ST_TRIP  = 3'd3;
    localparam logic [2:0] ST_RANGE = 3'd4;

    localparam logic [2:0] REG_CAL_CURRENT = 3'd0;
    localparam logic [2:0] REG_GAIN        = 3'd1;
    localparam logic [2:0] REG_SQ_LIMIT    = 3'd2;
    localparam logic [2:0] REG_R_MIN       = 3'd3;
    localparam logic [2:0] REG_R_MAX       = 3'd4;
    localparam logic [2:0] REG_TICKS       = 3'd5;
    localparam logic [2:0] REG_GIMBAL      = 3'd6;

    localparam int CFG_W = 62;

    typedef struct packed {
        logic [14:0] cal_current_ma;
        logic [15:0] voltage_gain;
        logic [61:0] voltage_square_limit;
        logic [31:0] resistance_min_uohm;
        logic [31:0] resistance_max_uohm;
        logic [15:0] tick_count;
        logic        skip_cal;
    } t_cfg;

    // controller -> datapath
    typedef struct packed {
        logic load_in;     // capture input sample
        logic clr_accum;   // start: clear accumulator
        logic square;      // compute |V|^2
        logic accum;       // add gain * error
        logic div_start;   // begin a division (duty or resistance)
        logic div_res;     // 1: resistance division, 0: duty
        logic div_step;    // one iteration
        logic r_check;     // range check, store
        logic set_trip;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic trip;
        logic div_done;
        logic r_ok;
    } t_sts;
endpackage

// File: rtl/prc_stream_if.sv
// Interface: valid/ready channel with a generic payload.
interface prc_stream_if #(parameter int W = 1);
    logic         valid;
    logic         ready;
    logic [W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/prc_datapath.sv
// Datapath: accumulator, squaring, shared iterative divider and range check.
module prc_datapath import prc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cfg        i_cfg,
    input  t_cmd        i_cmd,
    input  logic [15:0] i_current,
    input  logic [15:0] i_vbus,
    output t_sts        o_sts,
    output logic [15:0] o_duty,
    output logic [31:0] o_res,
    output logic        o_res_valid,
    output logic [1:0]  o_err
);
    logic signed [31:0] r_accum;
    logic signed [15:0] r_cur;
    logic [15:0]        r_vbus;
    logic               r_trip;
    logic [46:0]        r_num;    // dividend shift register
    logic [41:0]        r_den;
    logic [5:0]         r_cnt;
    logic               r_neg;
    logic               r_busy;
    logic [41:0]        r_rem;
    logic [41:0]        r_quo;
    logic [31:0]        r_res;
    logic               r_res_valid;
    logic [1:0]         r_err;
    logic [15:0]        r_duty;

    logic [31:0]        mag;
    logic [62:0]        sq;
    logic signed [17:0] err;
    logic signed [34:0] prod;
    logic signed [35:0] sum;
    logic [42:0]        trial;
    logic [31:0]        rval;

    assign mag  = r_accum[31] ? 32'(-r_accum) : r_accum;
    assign sq   = 63'(mag) * 63'(mag);
    assign err  = 18'(signed'({1'b0, i_cfg.cal_current_ma})) - 18'(r_cur);
    assign prod = 35'(signed'({1'b0, i_cfg.voltage_gain})) * 35'(err);
    assign sum  = 36'(r_accum) + 36'(prod);
    assign trial = {r_rem, r_num[46]} ;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_cur  <= signed'(i_current);
            r_vbus <= i_vbus;
        end
        if (i_cmd.square) r_trip <= (sq > 63'(i_cfg.voltage_square_limit));
        if (i_cmd.div_start) begin
            r_rem <= '0;
            r_quo <= '0;
            r_cnt <= 6'd47;
            r_neg <= r_accum[31];
            if (i_cmd.div_res) begin
                r_num <= 47'({mag, 10'd0}) - 47'({mag, 4'd0}) - 47'({mag, 3'd0});
                r_den <= 42'(i_cfg.cal_current_ma);
            end else begin
                r_num <= {mag, 15'd0};
                r_den <= 42'(r_vbus) * 42'd1000;
            end
        end else if (i_cmd.div_step && r_cnt != 6'd0) begin
            if (43'(trial) >= 43'(r_den)) begin
                r_rem <= 42'(trial - 43'(r_den));
                r_quo <= {r_quo[40:0], 1'b1};
            end else begin
                r_rem <= trial[41:0];
                r_quo <= {r_quo[40:0], 1'b0};
            end
            r_num <= {r_num[45:0], 1'b0};
            r_cnt <= r_cnt - 6'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_accum     <= '0;
            r_res       <= '0;
            r_res_valid <= 1'b0;
            r_err       <= '0;
            r_duty      <= '0;
            r_busy      <= 1'b0;
        end else begin
            r_busy <= i_cmd.div_start;
            if (i_cmd.clr_accum) r_accum <= '0;
            else if (i_cmd.accum) begin
                if (sum > 36'sd2147483647) r_accum <= 32'sh7fffffff;
                else if (sum < -36'sd2147483648) r_accum <= 32'sh80000000;
                else r_accum <= 32'(sum);
            end
            if (i_cmd.set_trip) r_err[0] <= 1'b1;
            if (i_cmd.div_step && r_cnt == 6'd0 && !i_cmd.div_res) begin
                if (r_vbus == 16'd0) r_duty <= '0;
                else if (r_quo > 42'd32767) r_duty <= r_neg ? -16'sd32767 : 16'sd32767;
                else r_duty <= r_neg ? 16'(-r_quo[15:0]) : r_quo[15:0];
            end
            if (i_cmd.r_check) begin
                if (o_sts.r_ok) begin
                    r_res       <= rval;
                    r_res_valid <= 1'b1;
                end else r_err[1] <= 1'b1;
            end
        end
    end

    assign rval = (i_cfg.cal_current_ma == 15'd0 || r_quo[41:32] != '0) ? 32'hffffffff
                                                                         : r_quo[31:0];
    assign o_sts.trip     = r_trip;
    assign o_sts.div_done = (r_cnt == 6'd0) && !r_busy;
    assign o_sts.r_ok     = rval > i_cfg.resistance_min_uohm
                         && rval < i_cfg.resistance_max_uohm;
    assign o_duty      = r_duty;
    assign o_res       = r_res;
    assign o_res_valid = r_res_valid;
    assign o_err       = r_err;
endmodule

// File: rtl/prc_ctrl.sv
// Controller: sequences one request through the datapath and emits results.
module prc_ctrl import prc_pkg::*; #(parameter int TW = 16) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cfg        i_cfg,
    input  logic        i_in_valid,
    input  logic        i_action,
    output logic        o_in_ready,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [2:0]  o_status,
    output logic        o_last,
    output logic        o_duty_zero,
    output t_cmd        o_cmd,
    input  t_sts        i_sts
);
    localparam logic [3:0] S_IDLE = 4'd0, S_SQ = 4'd1, S_CHK = 4'd2, S_DDIV = 4'd3,
                           S_OUT = 4'd4, S_RDIV = 4'd5, S_RCHK = 4'd6, S_OUT2 = 4'd7,
                           S_DGO = 4'd8;
    logic [3:0]    r_st, n_st;
    logic          r_run, n_run;
    logic [TW-1:0] r_ticks, n_ticks;
    logic [2:0]    r_status, n_status;
    logic          r_last, n_last, r_zero, n_zero, r_final, n_final;
    logic [TW-1:0] target;
    localparam logic [TW-1:0] CMAX = '1;

    always_comb begin
        if (i_cfg.tick_count == 16'd0) target = TW'(1);
        else if (32'(i_cfg.tick_count) > 32'(CMAX)) target = CMAX;
        else target = TW'(i_cfg.tick_count);
    end

    assign o_in_ready  = (r_st == S_IDLE);
    assign o_out_valid = (r_st == S_OUT) || (r_st == S_OUT2);
    assign o_status    = r_status;
    assign o_last      = r_last;
    assign o_duty_zero = r_zero;

    always_comb begin
        n_st = r_st; n_run = r_run; n_ticks = r_ticks; n_status = r_status;
        n_last = r_last; n_zero = r_zero; n_final = r_final;
        o_cmd = '0;
        case (r_st)
            S_IDLE: if (i_in_valid) begin
                o_cmd.load_in = 1'b1;
                n_last = 1'b1; n_zero = 1'b1;
                if (!i_action) begin
                    o_cmd.clr_accum = 1'b1;
                    n_ticks = '0;
                    n_run = !i_cfg.skip_cal;
                    n_status = i_cfg.skip_cal ? ST_OK : ST_RUN;
                    n_st = S_OUT;
                end else if (!r_run) begin
                    n_status = ST_IDLE;
                    n_st = S_OUT;
                end else n_st = S_SQ;
            end
            S_SQ: begin
                o_cmd.square = 1'b1;
                n_st = S_CHK;
            end
            S_CHK: begin
                if (i_sts.trip) begin
                    o_cmd.set_trip = 1'b1;
                    n_run = 1'b0;
                    n_status = ST_TRIP;
                    n_st = S_OUT;
                end else begin
                    o_cmd.accum = 1'b1;
                    if (r_ticks != CMAX) n_ticks = r_ticks + TW'(1);
                    n_st = S_DGO;
                    n_status = ST_RUN;
                    n_zero = 1'b0;
                end
            end
            // divider loads the freshly updated accumulator
            S_DGO: begin
                o_cmd.div_start = 1'b1;
                n_st = S_DDIV;
            end
            S_DDIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_done) begin
                    n_final = (r_ticks >= target);
                    n_last = !(r_ticks >= target);
                    n_st = S_OUT;
                end
            end
            S_OUT: if (i_out_ready) begin
                if (r_final) begin
                    n_final = 1'b0;
                    n_run = 1'b0;
                    o_cmd.div_start = 1'b1;
                    o_cmd.div_res = 1'b1;
                    n_st = S_RDIV;
                end else n_st = S_IDLE;
            end
            S_RDIV: begin
                o_cmd.div_res = 1'b1;
                o_cmd.div_step = 1'b1;
                if (i_sts.div_done) n_st = S_RCHK;
            end
            S_RCHK: begin
                o_cmd.div_res = 1'b1;
                o_cmd.r_check = 1'b1;
                n_status = i_sts.r_ok ? ST_OK : ST_RANGE;
                n_zero = 1'b1; n_last = 1'b1;
                n_st = S_OUT2;
            end
            S_OUT2: if (i_out_ready) n_st = S_IDLE;
            default: n_st = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE; r_run <= 1'b0; r_ticks <= '0; r_status <= ST_IDLE;
            r_last <= 1'b0; r_zero <= 1'b1; r_final <= 1'b0;
        end else begin
            r_st <= n_st; r_run <= n_run; r_ticks <= n_ticks; r_status <= n_status;
            r_last <= n_last; r_zero <= n_zero; r_final <= n_final;
        end
    end

    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !o_in_ready) else $error("accept while result pending");
    a_final_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && r_final) |-> !o_last) else $error("final tick marked last");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_status)))
        else $error("result dropped");
endmodule

// File: rtl/phase_resistance_calibrator.sv
// Phase resistance calibrator top level.
// Start and idle ticks: result in the cycle after accept; voltage trip: via S_SQ and S_CHK.
// Run ticks: S_SQ, S_CHK, S_DGO, S_DDIV, with the 47-step radix-2 divider for the duty.
// Final tick adds a second result after the first is taken (resistance
// division on the same divider). Next request is taken in the cycle after the last result.
// Reset (i_rst_n low, synchronous) clears state and loads register defaults.
module phase_resistance_calibrator import prc_pkg::*; #(
    parameter int TICK_COUNTER_WIDTH = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [2:0]        i_cfg_idx,
    input  logic [CFG_W-1:0]  i_cfg_data,
    prc_stream_if.sink        in_ch,
    prc_stream_if.source      out_ch
);
    t_cfg        r_cfg;
    t_cmd        cmd;
    t_sts        sts;
    logic [15:0] duty;
    logic [31:0] res;
    logic        res_valid, last, zero;
    logic [1:0]  err;
    logic [2:0]  status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.cal_current_ma       <= 15'd6000;
            r_cfg.voltage_gain         <= 16'd100;
            r_cfg.voltage_square_limit <= '1;
            r_cfg.resistance_min_uohm  <= 32'd10000;
            r_cfg.resistance_max_uohm  <= 32'd1000000;
            r_cfg.tick_count           <= 16'd4096;
            r_cfg.skip_cal             <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_CAL_CURRENT: r_cfg.cal_current_ma       <= i_cfg_data[14:0];
                REG_GAIN:        r_cfg.voltage_gain         <= i_cfg_data[15:0];
                REG_SQ_LIMIT:    r_cfg.voltage_square_limit <= i_cfg_data;
                REG_R_MIN:       r_cfg.resistance_min_uohm  <= i_cfg_data[31:0];
                REG_R_MAX:       r_cfg.resistance_max_uohm  <= i_cfg_data[31:0];
                REG_TICKS:       r_cfg.tick_count           <= i_cfg_data[15:0];
                REG_GIMBAL:      r_cfg.skip_cal             <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    prc_ctrl #(.TW(TICK_COUNTER_WIDTH)) u_ctrl (
        .i_clk, .i_rst_n, .i_cfg(r_cfg),
        .i_in_valid(in_ch.valid), .i_action(in_ch.data[0]), .o_in_ready(in_ch.ready),
        .o_out_valid(out_ch.valid), .i_out_ready(out_ch.ready),
        .o_status(status), .o_last(last), .o_duty_zero(zero),
        .o_cmd(cmd), .i_sts(sts)
    );

    prc_datapath u_dp (
        .i_clk, .i_rst_n, .i_cfg(r_cfg), .i_cmd(cmd),
        .i_current(in_ch.data[16:1]), .i_vbus(in_ch.data[32:17]),
        .o_sts(sts), .o_duty(duty), .o_res(res), .o_res_valid(res_valid), .o_err(err)
    );

    // payload: duty, status, resistance, valid, errors, last
    assign out_ch.data = {last, err, res_valid, res, status, zero ? 16'd0 : duty};
endmodule
